FILE: hw/rtl/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg: shared types and codes for the rank select block
// Action codes, word widths and the structs that run along the cell row.
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int unsigned ValueW = 32;
    localparam int unsigned RankW  = 8;
    localparam int unsigned ActW   = 2;

    localparam logic [ActW-1:0] ACT_APPEND = 2'd0;
    localparam logic [ActW-1:0] ACT_QUERY  = 2'd1;
    localparam logic [ActW-1:0] ACT_CLEAR  = 2'd2;

    typedef logic signed [ValueW-1:0] value_t;
    typedef logic [RankW-1:0]         rank_t;
    typedef logic [ActW-1:0]          action_t;

    // broadcast from the control to every cell
    typedef struct packed {
        logic   ins;     // insert value this cycle
        logic   tok_en;  // query token advances this cycle
        value_t value;   // value being inserted
        rank_t  rank;    // rank of the query in flight
    } rss_bcast_t;

    // handed from one cell to its right neighbor
    typedef struct packed {
        logic   gt;       // neighbor holds a value above the insert value (or is empty)
        value_t val;      // neighbor's stored value
        logic   tok_vld;  // query token present
        value_t tok_data; // value picked up by the token
    } rss_link_t;

endpackage

FILE: hw/rtl/rank_select_after_sort.sv
// ----------------------------------------------------------------------------
// rank_select_after_sort: ordered value store with select by rank
// Keeps up to CAPACITY signed words in ascending order in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: s_action selects append (s_value), query (s_rank) or
//   clear. Result channel m_*: one word per query whose rank lies from 1 to
//   the current count, carrying the value and the rank it answers.
//   Append, clear, unused codes and out-of-range queries keep s_ready high and
//   may follow back to back. Appends to a full store are dropped.
//   An in-range query sends a token down the cell row, one cell a cycle; it
//   picks up the matching cell's value and lands in the output register.
//   s_ready stays low while the token is in flight. If the receiver stalls,
//   the token waits in the last cell; further items are taken once the
//   result has moved into the output register.
//   Reset empties the store and drops any query in flight; stored values
//   are not cleared, the count alone marks what is valid.
// ----------------------------------------------------------------------------
module rank_select_after_sort #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  rss_pkg::action_t       s_action,
    input  rss_pkg::value_t        s_value,
    input  rss_pkg::rank_t         s_rank,
    output logic                   m_valid,
    input  logic                   m_ready,
    output rss_pkg::value_t        m_selected_value,
    output rss_pkg::rank_t         m_echoed_rank
);
    import rss_pkg::*;

    localparam int unsigned CntW = $clog2(CAPACITY + 1);

    logic [CntW-1:0]  count_reg;
    logic [CntW-1:0]  count_next;
    logic             busy_reg;
    logic             busy_next;
    rank_t            rank_reg;
    logic             m_valid_reg;
    value_t           m_value_reg;
    rank_t            m_rank_reg;

    logic             accept;
    logic             do_ins;
    logic             q_start;
    logic             out_load;
    logic             full;
    logic             in_range;
    rss_bcast_t       bcast;
    rss_link_t        lnk [0:CAPACITY];
    logic [CAPACITY-1:0] tok_vec;

    assign accept   = s_valid && s_ready;
    assign full     = (32'(count_reg) >= 32'(CAPACITY));
    assign in_range = (s_rank != '0) && (32'(s_rank) <= 32'(count_reg));
    assign s_ready  = !busy_reg;

    always_comb begin
        do_ins     = 1'b0;
        q_start    = 1'b0;
        count_next = count_reg;
        if (accept) begin
            unique case (s_action)
                ACT_APPEND: begin
                    if (!full) begin
                        do_ins     = 1'b1;
                        count_next = count_reg + CntW'(1);
                    end
                end
                ACT_QUERY: begin
                    q_start = in_range;
                end
                ACT_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // token leaves the last cell into the output register
    assign out_load  = lnk[CAPACITY].tok_vld && (!m_valid_reg || m_ready);
    assign busy_next = q_start || (busy_reg && !out_load);

    assign bcast.ins    = do_ins;
    assign bcast.tok_en = !(lnk[CAPACITY].tok_vld && !out_load);
    assign bcast.value  = s_value;
    // the first cell meets the token in the accept cycle, before rank_reg loads
    assign bcast.rank   = q_start ? s_rank : rank_reg;

    assign lnk[0].gt       = 1'b0;
    assign lnk[0].val      = s_value;
    assign lnk[0].tok_vld  = q_start;
    assign lnk[0].tok_data = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        rss_cell #(
            .INDEX    (i),
            .CAPACITY (CAPACITY)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .bcast   (bcast),
            .count   (count_reg),
            .left    (lnk[i]),
            .right   (lnk[i+1])
        );
        assign tok_vec[i] = lnk[i+1].tok_vld;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // the query rank must be stable before the token reaches the matching cell
    always_ff @(posedge aclk) begin
        if (q_start) begin
            rank_reg <= s_rank;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_value_reg <= lnk[CAPACITY].tok_data;
            m_rank_reg  <= rank_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_selected_value = m_value_reg;
    assign m_echoed_rank    = m_rank_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(CAPACITY))
        else $error("entry count above capacity");

    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_vec))
        else $error("more than one query token in the row");

    a_token_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (tok_vec != '0) |-> busy_reg)
        else $error("query token present while block not busy");

    a_result_from_query: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(busy_reg))
        else $error("result word without a query in flight");

    a_no_ins_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !do_ins)
        else $error("insert while a query is in flight");

endmodule

FILE: hw/rtl/rss_cell.sv
// ----------------------------------------------------------------------------
// rss_cell: one slot of the ordered value row
// Holds one value; on insert keeps, takes the new value or shifts in its left
// neighbor's value. Also passes the query token one slot per cycle while bcast.tok_en is high.
// ----------------------------------------------------------------------------
module rss_cell #(
    parameter int unsigned INDEX    = 0,
    parameter int unsigned CAPACITY = 128
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rss_pkg::rss_bcast_t                  bcast,
    input  logic [$clog2(CAPACITY+1)-1:0]        count,
    input  rss_pkg::rss_link_t                   left,
    output rss_pkg::rss_link_t                   right
);
    import rss_pkg::*;

    value_t store_reg;
    logic   tok_vld_reg;
    value_t tok_data_reg;
    logic   occupied;
    logic   gt;
    logic   hit;

    assign occupied = (INDEX < int'(count));
    // an empty slot counts as "greater", so the row stays sorted
    assign gt       = !occupied || (store_reg > bcast.value);
    assign hit      = left.tok_vld && (int'(bcast.rank) == int'(INDEX) + 1);

    always_ff @(posedge aclk) begin
        if (bcast.ins && gt) begin
            store_reg <= left.gt ? left.val : bcast.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_vld_reg <= 1'b0;
        end else if (bcast.tok_en) begin
            tok_vld_reg <= left.tok_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (bcast.tok_en) begin
            tok_data_reg <= hit ? store_reg : left.tok_data;
        end
    end

    assign right.gt       = gt;
    assign right.val      = store_reg;
    assign right.tok_vld  = tok_vld_reg;
    assign right.tok_data = tok_data_reg;

endmodule

FILE: dv/rank_select_after_sort_tb.sv
// ----------------------------------------------------------------------------
// rank_select_after_sort_tb: self-checking bench for the rank select block
// Drives append, query, clear and unused words with random bursts and gaps,
// keeps a sorted shadow copy of the store to predict every query answer, and
// checks each result word in order while the receiver stalls on its own.
// ----------------------------------------------------------------------------
module rank_select_after_sort_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rss_pkg::*;

    localparam int unsigned CAPACITY    = 128;
    localparam int unsigned CYCLE_LIMIT = 800_000;
    localparam int unsigned WORD_TARGET = 770;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam action_t     ACT_UNUSED  = 2'd3;

    typedef struct {
        value_t value;
        rank_t  rank;
    } answer_t;

    // shadow of the ordered store plus the answers still owed by the block
    class rank_scoreboard;
        int unsigned capacity;
        value_t      sorted_q[$];
        answer_t     expected_q[$];
        int unsigned errors;
        int unsigned answers_checked;
        int unsigned appends_dropped;

        function new(int unsigned cap);
            capacity        = cap;
            errors          = 0;
            answers_checked = 0;
            appends_dropped = 0;
        endfunction

        function void note_word(action_t act, value_t val, rank_t rk);
            int unsigned pos;
            answer_t     ans;
            if (act == ACT_APPEND) begin
                if (sorted_q.size() < capacity) begin
                    // equal values stay ahead of the new one
                    pos = sorted_q.size();
                    while (pos > 0 && sorted_q[pos-1] > val) pos--;
                    sorted_q.insert(pos, val);
                end else begin
                    appends_dropped++;
                end
            end else if (act == ACT_CLEAR) begin
                sorted_q.delete();
            end else if (act == ACT_QUERY) begin
                if (rk >= 1 && rk <= sorted_q.size()) begin
                    ans.value = sorted_q[rk-1];
                    ans.rank  = rk;
                    expected_q.push_back(ans);
                end
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(value_t val, rank_t rk);
            answer_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word value %0d rank %0d", val, rk));
                return;
            end
            want = expected_q.pop_front();
            answers_checked++;
            if (val !== want.value)
                report_mismatch($sformatf("rank %0d: value %0d, want %0d",
                                          want.rank, val, want.value));
            if (rk !== want.rank)
                report_mismatch($sformatf("echoed rank %0d, want %0d", rk, want.rank));
        endtask
    endclass

    logic    aclk = 1'b0;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    action_t s_action;
    value_t  s_value;
    rank_t   s_rank;
    logic    m_valid;
    logic    m_ready;
    value_t  m_selected_value;
    rank_t   m_echoed_rank;

    rank_scoreboard board;
    int unsigned    cycle_count     = 0;
    int unsigned    words_sent      = 0;
    int unsigned    burst_left      = 0;
    int unsigned    holds_requested = 0;
    int unsigned    holds_done      = 0;

    rank_select_after_sort #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_value         (s_value),
        .s_rank          (s_rank),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_selected_value(m_selected_value),
        .m_echoed_rank   (m_echoed_rank)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
            board.check_result(m_selected_value, m_echoed_rank);
    end

    // receiver: changing stall patterns, plus one long hold-off on request
    initial begin
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned mode;
        int unsigned phase;
        hold_left = 0;
        mode_left = 0;
        mode      = 0;
        phase     = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_done < holds_requested) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(64, 256);
                end
                mode_left--;
                phase++;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 9) < 7);
                    2: m_ready <= (phase % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // offer one word and hold it until taken; bursts may end in random gaps
    task automatic offer(action_t act, value_t val, rank_t rk);
        int unsigned gap;
        s_valid  <= 1'b1;
        s_action <= act;
        s_value  <= val;
        s_rank   <= rk;
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.note_word(act, val, rk);
        if (act != ACT_UNUSED) words_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    function automatic value_t pick_value(int unsigned flavor);
        case (flavor)
            0: return value_t'($urandom);
            1: return value_t'(int'($urandom_range(0, 8)) - 4);  // many duplicates
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return '0;
                    3: return '1;
                    default: return value_t'($urandom_range(1, 3));
                endcase
            end
        endcase
    endfunction

    function automatic rank_t pick_rank();
        int unsigned cnt;
        int unsigned sel;
        cnt = board.sorted_q.size();
        sel = $urandom_range(0, 9);
        if (sel < 6 && cnt > 0) return rank_t'($urandom_range(1, cnt));
        if (sel == 6) return rank_t'(cnt + 1);
        if (sel == 7) return '0;
        if (sel == 8) return rank_t'(cnt);
        return rank_t'($urandom_range(0, 255));
    endfunction

    task automatic query_run(int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++) offer(ACT_QUERY, value_t'($urandom), pick_rank());
    endtask

    // fill past capacity so the last appends are dropped
    task automatic fill_run(bit with_hold);
        int unsigned i;
        int unsigned flavor;
        flavor = $urandom_range(0, 2);
        offer(ACT_CLEAR, value_t'($urandom), rank_t'($urandom));
        for (i = 0; i < CAPACITY + 4; i++)
            offer(ACT_APPEND, pick_value(flavor), rank_t'($urandom));
        if (with_hold) holds_requested++;
        offer(ACT_QUERY, value_t'($urandom), 8'd1);
        offer(ACT_QUERY, value_t'($urandom), rank_t'(CAPACITY));
        offer(ACT_QUERY, value_t'($urandom), rank_t'(CAPACITY + 1));
        query_run(3);
    endtask

    task automatic probe_run(bit keep_store);
        int unsigned i;
        int unsigned n;
        int unsigned flavor;
        if (!keep_store && $urandom_range(0, 1))
            offer(ACT_CLEAR, value_t'($urandom), rank_t'($urandom));
        flavor = $urandom_range(0, 2);
        n = $urandom_range(1, 24);
        for (i = 0; i < n; i++) offer(ACT_APPEND, pick_value(flavor), rank_t'($urandom));
        query_run($urandom_range(1, 6));
    endtask

    task automatic noise_run();
        int unsigned i;
        int unsigned n;
        n = $urandom_range(2, 8);
        for (i = 0; i < n; i++)
            offer(action_t'($urandom_range(0, 3)), value_t'($urandom), rank_t'($urandom));
    endtask

    initial begin
        int unsigned kind;
        board = new(CAPACITY);
        aresetn  <= 1'b0;
        s_valid  <= 1'b0;
        s_action <= ACT_APPEND;
        s_value  <= '0;
        s_rank   <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty store, extremes, duplicates, ignored fields, clear
        offer(ACT_QUERY,  '0, 8'd1);
        offer(ACT_APPEND, 32'sh7FFF_FFFF, '0);
        offer(ACT_APPEND, 32'sh8000_0000, '0);
        offer(ACT_APPEND, '0, '0);
        offer(ACT_APPEND, '0, 8'hFF);
        offer(ACT_APPEND, '1, '0);
        offer(ACT_QUERY,  '0, 8'd1);
        offer(ACT_QUERY,  '0, 8'd5);
        offer(ACT_QUERY,  '0, 8'd3);
        offer(ACT_QUERY,  '0, 8'd6);
        offer(ACT_QUERY,  '0, 8'd0);
        offer(ACT_QUERY,  '0, 8'hFF);
        offer(ACT_UNUSED, '1, 8'hFF);
        offer(ACT_QUERY,  32'sh5A5A_A5A5, 8'd2);
        offer(ACT_QUERY,  '0, 8'd4);
        offer(ACT_CLEAR,  '1, 8'hFF);
        offer(ACT_QUERY,  '0, 8'd1);
        offer(ACT_APPEND, 32'sd5, '0);
        offer(ACT_QUERY,  '0, 8'd1);

        // random: one full store under a long receiver hold, then mixed runs
        fill_run(1'b1);
        while (words_sent < WORD_TARGET) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                fill_run(1'b0);
            end else if (kind < 4) begin
                noise_run();
            end else if (kind < 6) begin
                offer(ACT_CLEAR, value_t'($urandom), rank_t'($urandom));
                query_run($urandom_range(1, 3));
            end else begin
                probe_run(kind > 16);
            end
        end
        s_valid <= 1'b0;

        while (board.expected_q.size() != 0) @(posedge aclk);
        repeat (CAPACITY + 16) @(posedge aclk);

        $display("Summary: %0d words sent, %0d answers checked, %0d appends dropped on a full store",
                 words_sent, board.answers_checked, board.appends_dropped);
        $display("Summary: %0d cycles, %0d mismatches", cycle_count, board.errors);
        if (board.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/rss_pkg.sv
hw/rtl/rss_cell.sv
hw/rtl/rank_select_after_sort.sv
dv/rank_select_after_sort_tb.sv
